// ===== rtl/core/grid_wavefront_path_planner_core_defines.svh =====
// Assertion helpers shared by the planner RTL.
`ifndef GRID_WAVEFRONT_PATH_PLANNER_CORE_DEFINES_SVH
`define GRID_WAVEFRONT_PATH_PLANNER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define GWPP_ASSERT_IMP(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("gwpp: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define GWPP_ASSERT_NXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("gwpp: assertion failed");

`endif

// ===== rtl/core/gwpp_pkg.sv =====
package gwpp_pkg;

   localparam int COST_W   = 22;
   localparam int COORD_W  = 6;
   localparam int MAXC_W   = 21;
   localparam int LIMIT_W  = 12;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 12;

   localparam logic [COST_W-1:0] COST_NONE = 22'h3FFFFF;
   localparam logic [COST_W-1:0] COST_TOP  = 22'h3FFFFE;

   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_PLAN = 2'd1;
   localparam logic [1:0] REQ_STEP = 2'd2;

   localparam logic [2:0] ST_PLANNED   = 3'd0;
   localparam logic [2:0] ST_UNREACHED = 3'd1;
   localparam logic [2:0] ST_STEP      = 3'd2;
   localparam logic [2:0] ST_AT_GOAL   = 3'd3;
   localparam logic [2:0] ST_STUCK     = 3'd4;
   localparam logic [2:0] ST_NO_PLAN   = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROBOT_X = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROBOT_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FREE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_REACH   = 3'd5;

   localparam logic [1:0] OFF_MINUS = 2'd0;
   localparam logic [1:0] OFF_ZERO  = 2'd1;
   localparam logic [1:0] OFF_PLUS  = 2'd2;

   // Neighbours are visited in row-major order, the center cell skipped.
   function automatic logic [1:0] nbr_dy(input logic [2:0] k);
      logic [1:0] r;
      if (k < 3'd3) r = OFF_MINUS;
      else if (k < 3'd5) r = OFF_ZERO;
      else r = OFF_PLUS;
      return r;
   endfunction

   function automatic logic [1:0] nbr_dx(input logic [2:0] k);
      logic [1:0] r;
      unique case (k)
         3'd0, 3'd3, 3'd5: r = OFF_MINUS;
         3'd1, 3'd6:       r = OFF_ZERO;
         default:          r = OFF_PLUS;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/gwpp_reach.sv =====
module gwpp_reach
   import gwpp_pkg::*;
#(
   parameter int CW = 6,
   parameter int CMPW = 6
) (
   input  logic               clock,
   input  logic [CW-1:0]      nx,
   input  logic [CW-1:0]      ny,
   input  logic [CMPW:0]      gsum_x,
   input  logic [CMPW:0]      gsum_y,
   input  logic [LIMIT_W-1:0] limit,
   output logic               in_reach
);

   localparam int DW = CMPW + 3;
   localparam int QW = 2 * DW;
   localparam int SW = QW + 7;

   logic signed [DW-1:0] dx, dy;
   logic signed [QW-1:0] dxe, dye;
   logic [QW-1:0] dx_sq_ff, dy_sq_ff;
   logic [2*LIMIT_W-1:0] lim_sq_ff;
   logic [SW-1:0] lhs;

   assign dx = $signed(DW'({nx, 1'b0})) - $signed(DW'(gsum_x));
   assign dy = $signed(DW'({ny, 1'b0})) - $signed(DW'(gsum_y));
   assign dxe = QW'(dx);
   assign dye = QW'(dy);

   always_ff @(posedge clock) begin
      dx_sq_ff  <= QW'(dxe * dxe);
      dy_sq_ff  <= QW'(dye * dye);
      lim_sq_ff <= (2*LIMIT_W)'(limit * limit);
   end

   // Scaled squared distance to the midpoint against the squared Q4 limit.
   assign lhs = {SW'({1'b0, dx_sq_ff} + {1'b0, dy_sq_ff})} << 6;
   assign in_reach = lhs <= SW'(lim_sq_ff);

endmodule

// ===== rtl/core/grid_wavefront_path_planner_core.sv =====
// Channel     Ports                       Handshake
// request     start, busy, req_*          taken when start is high and busy is low
// response    rsp_strobe, rsp_*           one-cycle strobe, always taken
// csr write   csr_valid, csr_ready, csr_* taken when valid and ready are high
//
// A load transaction keeps busy low.
// A plan sweeps the cost memory one entry per cycle, then for each dequeued cell reads
// the queue and that cell's cost and reads and evaluates each neighbour inside the grid,
// skipping those outside it, and at the end checks the cost of the robot cell.
// A step reads the traced cell's cost, then each neighbour inside the grid.
// Reset is synchronous; after it no plan exists and steps answer not planned. The
// response side cannot stall: the strobe comes in the first cycle with busy low again.
`include "grid_wavefront_path_planner_core_defines.svh"

module grid_wavefront_path_planner_core
   import gwpp_pkg::*;
#(
   parameter int GRID_SIDE = 64,
   parameter int COST_FRAC_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_type,
   input  logic [COORD_W-1:0]   req_cell_x,
   input  logic [COORD_W-1:0]   req_cell_y,
   input  logic [7:0]           req_cell_value,
   input  logic                 req_cell_unknown,
   output logic                 rsp_strobe,
   output logic [2:0]           rsp_status,
   output logic [COORD_W-1:0]   rsp_path_x,
   output logic [COORD_W-1:0]   rsp_path_y,
   output logic [MAXC_W-1:0]    rsp_max_cost,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   localparam int CW    = $clog2(GRID_SIDE);
   localparam int AW    = 2 * CW;
   localparam int DEPTH = 1 << AW;
   localparam int CMPW  = (CW > COORD_W) ? CW : COORD_W;
   localparam int PW    = AW + 1;
   localparam logic [COST_W-1:0] STEP_S = COST_W'(1 << COST_FRAC_BITS);
   localparam logic [COST_W-1:0] STEP_D =
      COST_W'((92682 + (1 << (15 - COST_FRAC_BITS))) >> (16 - COST_FRAC_BITS));

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CLR   = 4'd1;
   localparam logic [3:0] S_PINIT = 4'd2;
   localparam logic [3:0] S_POP   = 4'd3;
   localparam logic [3:0] S_POPW  = 4'd4;
   localparam logic [3:0] S_CURW  = 4'd5;
   localparam logic [3:0] S_NRD   = 4'd6;
   localparam logic [3:0] S_NEV   = 4'd7;
   localparam logic [3:0] S_ROB   = 4'd8;
   localparam logic [3:0] S_STW   = 4'd9;
   localparam logic [3:0] S_SRD   = 4'd10;
   localparam logic [3:0] S_SEV   = 4'd11;
   localparam logic [3:0] S_SDONE = 4'd12;

   // Configuration registers.
   logic [COORD_W-1:0] goal_x_ff, goal_y_ff, robot_x_ff, robot_y_ff;
   logic [7:0]         free_ff;
   logic [LIMIT_W-1:0] reach_ff;

   // Memories.
   logic              pass_mem [DEPTH];
   logic [COST_W-1:0] cost_mem [DEPTH];
   logic [AW-1:0]     queue_mem [DEPTH];
   logic              pass_rd_ff;
   logic [COST_W-1:0] cost_rd_ff;
   logic [AW-1:0]     q_rd_ff;

   // Control state.
   logic [3:0]  state_ff, state_in;
   logic [PW-1:0] clr_ff, clr_in, head_ff, head_in, tail_ff, tail_in;
   logic [2:0]  k_ff, k_in;
   logic        planned_ff, planned_in;
   logic        found_ff, found_in;
   logic        rsp_strobe_ff, rsp_strobe_in;

   // Payload registers.
   logic [AW-1:0]      cur_ff, cur_in, nb_ff, nb_in, trace_ff, trace_in, bcell_ff, bcell_in;
   logic [COST_W-1:0]  ccost_ff, ccost_in, best_ff, best_in, peak_ff, peak_in;
   logic               diag_ff, diag_in;
   logic [2:0]         rsp_status_ff, rsp_status_in;
   logic [COORD_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [MAXC_W-1:0]  rsp_max_ff, rsp_max_in;

   // Memory ports.
   logic              cost_we, q_we, pass_we;
   logic [AW-1:0]     cost_raddr, cost_waddr, q_raddr, q_waddr, pass_waddr;
   logic [COST_W-1:0] cost_wdata;
   logic [AW-1:0]     q_wdata;
   logic              pass_wdata;

   // Neighbour generation.
   logic [AW-1:0] base_idx, nb_idx;
   logic [CW-1:0] bx, by, nx, ny;
   logic          vx, vy, nvalid, ndiag;
   logic [1:0]    dxc, dyc;

   logic [CMPW-1:0] gx_e, gy_e, rx_e, ry_e, cx_e, cy_e;
   logic            ends_in_grid, trace_at_goal, accept, reach_ok;
   logic [COST_W:0] cand_sum;
   logic [COST_W-1:0] cand, step_cost;
   logic [AW-1:0]   goal_idx, robot_idx;
   logic [MAXC_W-1:0] peak_sat;

   function automatic logic [CW-1:0] req_cell_x_w(input logic [COORD_W-1:0] v);
      logic [CMPW-1:0] e;
      e = CMPW'(v);
      return e[CW-1:0];
   endfunction

   function automatic logic [CW-1:0] req_cell_y_w(input logic [COORD_W-1:0] v);
      logic [CMPW-1:0] e;
      e = CMPW'(v);
      return e[CW-1:0];
   endfunction

   assign accept    = start && !busy;
   assign busy      = state_ff != S_IDLE;
   assign csr_ready = 1'b1;

   assign gx_e = CMPW'(goal_x_ff);
   assign gy_e = CMPW'(goal_y_ff);
   assign rx_e = CMPW'(robot_x_ff);
   assign ry_e = CMPW'(robot_y_ff);
   assign ends_in_grid = ((CMPW+1)'(gx_e) < (CMPW+1)'(GRID_SIDE))
                      && ((CMPW+1)'(gy_e) < (CMPW+1)'(GRID_SIDE))
                      && ((CMPW+1)'(rx_e) < (CMPW+1)'(GRID_SIDE))
                      && ((CMPW+1)'(ry_e) < (CMPW+1)'(GRID_SIDE));
   assign goal_idx  = {gy_e[CW-1:0], gx_e[CW-1:0]};
   assign robot_idx = {ry_e[CW-1:0], rx_e[CW-1:0]};
   assign cx_e = CMPW'(trace_ff[CW-1:0]);
   assign cy_e = CMPW'(trace_ff[AW-1:CW]);
   assign trace_at_goal = (cx_e == gx_e) && (cy_e == gy_e);
   assign peak_sat = peak_ff[COST_W-1] ? {MAXC_W{1'b1}} : peak_ff[MAXC_W-1:0];

   assign step_cost = diag_ff ? STEP_D : STEP_S;
   assign cand_sum  = {1'b0, ccost_ff} + {1'b0, step_cost};
   assign cand      = (cand_sum > {1'b0, COST_TOP}) ? COST_TOP : cand_sum[COST_W-1:0];

   always_comb begin
      base_idx = (state_ff == S_SRD) ? trace_ff : cur_ff;
      bx  = base_idx[CW-1:0];
      by  = base_idx[AW-1:CW];
      dxc = nbr_dx(k_ff);
      dyc = nbr_dy(k_ff);
      unique case (dxc)
         OFF_MINUS: begin nx = bx - 1'b1; vx = bx != '0; end
         OFF_PLUS: begin
            nx = bx + 1'b1;
            vx = ({1'b0, bx} + 1'b1) < (CW+1)'(GRID_SIDE);
         end
         default: begin nx = bx; vx = 1'b1; end
      endcase
      unique case (dyc)
         OFF_MINUS: begin ny = by - 1'b1; vy = by != '0; end
         OFF_PLUS: begin
            ny = by + 1'b1;
            vy = ({1'b0, by} + 1'b1) < (CW+1)'(GRID_SIDE);
         end
         default: begin ny = by; vy = 1'b1; end
      endcase
      nvalid = vx && vy;
      ndiag  = (dxc != OFF_ZERO) && (dyc != OFF_ZERO);
      nb_idx = {ny, nx};
   end

   gwpp_reach #(.CW(CW), .CMPW(CMPW)) u_reach (
      .clock    (clock),
      .nx       (nx),
      .ny       (ny),
      .gsum_x   ({1'b0, gx_e} + {1'b0, rx_e}),
      .gsum_y   ({1'b0, gy_e} + {1'b0, ry_e}),
      .limit    (reach_ff),
      .in_reach (reach_ok)
   );

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      k_in = k_ff;
      planned_in = planned_ff;
      found_in = found_ff;
      cur_in = cur_ff;
      nb_in = nb_ff;
      trace_in = trace_ff;
      bcell_in = bcell_ff;
      ccost_in = ccost_ff;
      best_in = best_ff;
      peak_in = peak_ff;
      diag_in = diag_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_x_in = '0;
      rsp_y_in = '0;
      rsp_max_in = '0;
      cost_raddr = nb_idx;
      cost_we = 1'b0;
      cost_waddr = nb_ff;
      cost_wdata = cand;
      q_we = 1'b0;
      q_waddr = tail_ff[AW-1:0];
      q_wdata = nb_ff;
      q_raddr = head_ff[AW-1:0];

      pass_we = accept && (req_type == REQ_LOAD)
             && ((CMPW+1)'(req_cell_x) < (CMPW+1)'(GRID_SIDE))
             && ((CMPW+1)'(req_cell_y) < (CMPW+1)'(GRID_SIDE));
      pass_waddr = {req_cell_y_w(req_cell_y), req_cell_x_w(req_cell_x)};
      pass_wdata = !req_cell_unknown && (req_cell_value <= free_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_type == REQ_PLAN) begin
               clr_in = '0;
               head_in = '0;
               tail_in = '0;
               peak_in = '0;
               planned_in = 1'b0;
               state_in = S_CLR;
            end else if (accept && req_type == REQ_STEP) begin
               if (!planned_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = ST_NO_PLAN;
               end else if (trace_at_goal) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = ST_AT_GOAL;
               end else begin
                  cost_raddr = trace_ff;
                  state_in = S_STW;
               end
            end
         end
         S_CLR: begin
            cost_we = 1'b1;
            cost_waddr = clr_ff[AW-1:0];
            cost_wdata = COST_NONE;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == PW'(DEPTH - 1)) state_in = S_PINIT;
         end
         S_PINIT: begin
            if (!ends_in_grid) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_UNREACHED;
               state_in = S_IDLE;
            end else begin
               cost_we = 1'b1;
               cost_waddr = goal_idx;
               cost_wdata = STEP_S;
               q_we = 1'b1;
               q_wdata = goal_idx;
               tail_in = tail_ff + 1'b1;
               peak_in = STEP_S;
               state_in = S_POP;
            end
         end
         S_POP: begin
            if (head_ff < tail_ff) begin
               head_in = head_ff + 1'b1;
               state_in = S_POPW;
            end else begin
               cost_raddr = robot_idx;
               state_in = S_ROB;
            end
         end
         S_POPW: begin
            cur_in = q_rd_ff;
            cost_raddr = q_rd_ff;
            state_in = S_CURW;
         end
         S_CURW: begin
            ccost_in = cost_rd_ff;
            k_in = '0;
            state_in = S_NRD;
         end
         S_NRD: begin
            if (nvalid) begin
               nb_in = nb_idx;
               diag_in = ndiag;
               state_in = S_NEV;
            end else begin
               k_in = k_ff + 1'b1;
               if (k_ff == 3'd7) state_in = S_POP;
            end
         end
         S_NEV: begin
            if (pass_rd_ff && reach_ok) begin
               if (cost_rd_ff == COST_NONE) begin
                  cost_we = 1'b1;
                  q_we = 1'b1;
                  tail_in = tail_ff + 1'b1;
                  if (cand > peak_ff) peak_in = cand;
               end else if (cost_rd_ff > cand) begin
                  cost_we = 1'b1;
               end
            end
            k_in = k_ff + 1'b1;
            state_in = (k_ff == 3'd7) ? S_POP : S_NRD;
         end
         S_ROB: begin
            rsp_strobe_in = 1'b1;
            rsp_max_in = peak_sat;
            if (cost_rd_ff == COST_NONE) begin
               rsp_status_in = ST_UNREACHED;
            end else begin
               rsp_status_in = ST_PLANNED;
               planned_in = 1'b1;
               trace_in = robot_idx;
            end
            state_in = S_IDLE;
         end
         S_STW: begin
            best_in = cost_rd_ff;
            found_in = 1'b0;
            k_in = '0;
            state_in = S_SRD;
         end
         S_SRD: begin
            if (nvalid) begin
               nb_in = nb_idx;
               state_in = S_SEV;
            end else begin
               k_in = k_ff + 1'b1;
               if (k_ff == 3'd7) state_in = S_SDONE;
            end
         end
         S_SEV: begin
            if (cost_rd_ff != COST_NONE && cost_rd_ff < best_ff) begin
               best_in = cost_rd_ff;
               bcell_in = nb_ff;
               found_in = 1'b1;
            end
            k_in = k_ff + 1'b1;
            state_in = (k_ff == 3'd7) ? S_SDONE : S_SRD;
         end
         S_SDONE: begin
            rsp_strobe_in = 1'b1;
            if (found_ff) begin
               trace_in = bcell_ff;
               rsp_status_in = ST_STEP;
               rsp_x_in = COORD_W'(CMPW'(bcell_ff[CW-1:0]));
               rsp_y_in = COORD_W'(CMPW'(bcell_ff[AW-1:CW]));
            end else begin
               rsp_status_in = ST_STUCK;
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pass_we) pass_mem[pass_waddr] <= pass_wdata;
      if (cost_we) cost_mem[cost_waddr] <= cost_wdata;
      if (q_we) queue_mem[q_waddr] <= q_wdata;
      pass_rd_ff <= pass_mem[cost_raddr];
      cost_rd_ff <= cost_mem[cost_raddr];
      q_rd_ff    <= queue_mem[q_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         clr_ff <= '0;
         head_ff <= '0;
         tail_ff <= '0;
         k_ff <= '0;
         planned_ff <= 1'b0;
         found_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         trace_ff <= '0;
         peak_ff <= '0;
         goal_x_ff <= '0;
         goal_y_ff <= '0;
         robot_x_ff <= '0;
         robot_y_ff <= '0;
         free_ff <= '0;
         reach_ff <= {LIMIT_W{1'b1}};
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         k_ff <= k_in;
         planned_ff <= planned_in;
         found_ff <= found_in;
         rsp_strobe_ff <= rsp_strobe_in;
         trace_ff <= trace_in;
         peak_ff <= peak_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_GOAL_X:  goal_x_ff <= csr_wdata[COORD_W-1:0];
               CSR_GOAL_Y:  goal_y_ff <= csr_wdata[COORD_W-1:0];
               CSR_ROBOT_X: robot_x_ff <= csr_wdata[COORD_W-1:0];
               CSR_ROBOT_Y: robot_y_ff <= csr_wdata[COORD_W-1:0];
               CSR_FREE:    free_ff <= csr_wdata[7:0];
               CSR_REACH:   reach_ff <= csr_wdata[LIMIT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      nb_ff <= nb_in;
      bcell_ff <= bcell_in;
      ccost_ff <= ccost_in;
      best_ff <= best_in;
      diag_ff <= diag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      rsp_max_ff <= rsp_max_in;
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_path_x   = rsp_x_ff;
   assign rsp_path_y   = rsp_y_ff;
   assign rsp_max_cost = rsp_max_ff;

   `GWPP_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_strobe, !busy)
   `GWPP_ASSERT_IMP(a_rsp_status_ok, clock, reset, rsp_strobe, rsp_status <= ST_NO_PLAN)
   `GWPP_ASSERT_NXT(a_plan_busy, clock, reset, accept && req_type == REQ_PLAN, busy)
   `GWPP_ASSERT_IMP(a_queue_order, clock, reset, 1'b1, head_ff <= tail_ff)
   `GWPP_ASSERT_IMP(a_step_planned, clock, reset, rsp_strobe && rsp_status == ST_STEP, planned_ff)

endmodule

// ===== tb/grid_wavefront_path_planner_core_tb.sv =====
`timescale 1ns / 100ps

module grid_wavefront_path_planner_core_tb
   import gwpp_pkg::*;
();

   localparam int SIDE = 64;
   localparam int CELLS = SIDE * SIDE;
   // Plans stay inside a loaded corner of AREA x AREA cells, fenced by a blocked ring.
   localparam int AREA = 16;
   localparam logic [COST_W-1:0] STRAIGHT = 22'd256;
   localparam logic [COST_W-1:0] DIAGONAL = 22'd362;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct {
      bit               is_csr;
      logic [CSR_IDX_W-1:0] idx;
      logic [CSR_DAT_W-1:0] wdata;
      logic [1:0]       kind;
      logic [5:0]       x;
      logic [5:0]       y;
      logic [7:0]       value;
      logic             unknown;
   } planner_op_t;

   typedef struct {
      logic [2:0]        status;
      logic [5:0]        px;
      logic [5:0]        py;
      logic [MAXC_W-1:0] peak;
   } planner_rsp_t;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [1:0] req_type = REQ_LOAD;
   logic [COORD_W-1:0] req_cell_x = 0, req_cell_y = 0;
   logic [7:0] req_cell_value = 0;
   logic req_cell_unknown = 0;
   logic rsp_strobe;
   logic [2:0] rsp_status;
   logic [COORD_W-1:0] rsp_path_x, rsp_path_y;
   logic [MAXC_W-1:0] rsp_max_cost;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = 0;
   logic [CSR_DAT_W-1:0] csr_wdata = 0;

   grid_wavefront_path_planner_core dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // Shadow copy of the planner state.
   int unsigned goal_x, goal_y, robot_x, robot_y, free_lvl, reach_q4 = 4095;
   bit pass_bits [CELLS];
   logic [COST_W-1:0] cost_shadow [CELLS];
   int unsigned wave [CELLS];
   int unsigned trace_pos;
   bit have_plan;

   planner_op_t pending_ops[$];
   planner_rsp_t awaited_rsps[$];
   bit fill_done = 0, stim_done = 0, failed = 0;
   int accepted_items = 0;
   int quiet_cycles = 0;

   function automatic bit in_reach(int x, int y);
      int dx, dy;
      dx = 2 * x - int'(goal_x + robot_x);
      dy = 2 * y - int'(goal_y + robot_y);
      return 64 * (dx * dx + dy * dy) <= int'(reach_q4 * reach_q4);
   endfunction

   function automatic planner_rsp_t run_wavefront();
      planner_rsp_t r;
      int head, tail, cur, cx, cy, nx, ny, n;
      logic [COST_W:0] sum;
      logic [COST_W-1:0] cand, peak;
      r = '{default: 0};
      for (int i = 0; i < CELLS; i++) cost_shadow[i] = COST_NONE;
      have_plan = 0;
      head = 0;
      tail = 0;
      cur = goal_y * SIDE + goal_x;
      cost_shadow[cur] = STRAIGHT;
      peak = STRAIGHT;
      wave[tail++] = cur;
      while (head < tail) begin
         cur = wave[head++];
         cx = cur % SIDE;
         cy = cur / SIDE;
         for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
               nx = cx + dx;
               ny = cy + dy;
               if ((dx == 0 && dy == 0) || nx < 0 || ny < 0 || nx >= SIDE || ny >= SIDE)
                  continue;
               n = ny * SIDE + nx;
               if (!pass_bits[n] || !in_reach(nx, ny)) continue;
               sum = cost_shadow[cur] + ((dx != 0 && dy != 0) ? DIAGONAL : STRAIGHT);
               cand = (sum > COST_TOP) ? COST_TOP : sum[COST_W-1:0];
               if (cost_shadow[n] == COST_NONE) begin
                  cost_shadow[n] = cand;
                  wave[tail++] = n;
                  if (cand > peak) peak = cand;
               end else if (cost_shadow[n] > cand) begin
                  cost_shadow[n] = cand;
               end
            end
         end
      end
      r.peak = (peak > 22'h1FFFFF) ? 21'h1FFFFF : peak[MAXC_W-1:0];
      if (cost_shadow[robot_y * SIDE + robot_x] == COST_NONE) begin
         r.status = ST_UNREACHED;
      end else begin
         r.status = ST_PLANNED;
         have_plan = 1;
         trace_pos = robot_y * SIDE + robot_x;
      end
      return r;
   endfunction

   function automatic planner_rsp_t next_path_cell();
      planner_rsp_t r;
      int cx, cy, nx, ny, n, best_cell;
      logic [COST_W-1:0] best;
      r = '{default: 0};
      if (!have_plan) begin
         r.status = ST_NO_PLAN;
         return r;
      end
      cx = trace_pos % SIDE;
      cy = trace_pos / SIDE;
      if (cx == goal_x && cy == goal_y) begin
         r.status = ST_AT_GOAL;
         return r;
      end
      best = cost_shadow[trace_pos];
      best_cell = -1;
      for (int dy = -1; dy <= 1; dy++) begin
         for (int dx = -1; dx <= 1; dx++) begin
            nx = cx + dx;
            ny = cy + dy;
            if ((dx == 0 && dy == 0) || nx < 0 || ny < 0 || nx >= SIDE || ny >= SIDE)
               continue;
            n = ny * SIDE + nx;
            if (cost_shadow[n] != COST_NONE && cost_shadow[n] < best) begin
               best = cost_shadow[n];
               best_cell = n;
            end
         end
      end
      if (best_cell < 0) begin
         r.status = ST_STUCK;
      end else begin
         trace_pos = best_cell;
         r.status = ST_STEP;
         r.px = 6'(best_cell % SIDE);
         r.py = 6'(best_cell / SIDE);
      end
      return r;
   endfunction

   task automatic predict_item(input logic [1:0] kind, input logic [5:0] x, input logic [5:0] y,
                               input logic [7:0] value, input logic unknown);
      planner_rsp_t r;
      case (kind)
         REQ_LOAD: pass_bits[y * SIDE + x] = !unknown && value <= free_lvl;
         REQ_PLAN: begin
            r = run_wavefront();
            awaited_rsps = {awaited_rsps, r};
         end
         REQ_STEP: begin
            r = next_path_cell();
            awaited_rsps = {awaited_rsps, r};
         end
         default: ;
      endcase
   endtask

   task automatic apply_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] d);
      case (idx)
         CSR_GOAL_X:  goal_x = d[5:0];
         CSR_GOAL_Y:  goal_y = d[5:0];
         CSR_ROBOT_X: robot_x = d[5:0];
         CSR_ROBOT_Y: robot_y = d[5:0];
         CSR_FREE:    free_lvl = d[7:0];
         CSR_REACH:   reach_q4 = d;
         default: ;
      endcase
   endtask

   // Driver: items go out from the pending queue; register writes wait for an idle block.
   always @(posedge clock) begin
      logic nxt_start, nxt_csr;
      planner_op_t op;
      if (reset) begin
         start <= 0;
         csr_valid <= 0;
      end else begin
         nxt_start = start;
         nxt_csr = csr_valid;
         if (start && !busy) begin
            predict_item(req_type, req_cell_x, req_cell_y, req_cell_value, req_cell_unknown);
            accepted_items++;
            nxt_start = 0;
         end
         if (csr_valid && csr_ready) begin
            apply_csr(csr_index, csr_wdata);
            nxt_csr = 0;
         end
         if (awaited_rsps.size() == 0 && !start && !busy) quiet_cycles++;
         else quiet_cycles = 0;
         if (!nxt_start && !nxt_csr && pending_ops.size() > 0) begin
            op = pending_ops[0];
            if (op.is_csr) begin
               if (quiet_cycles >= 8 && awaited_rsps.size() == 0) begin
                  void'(pending_ops.pop_front());
                  nxt_csr = 1;
                  csr_index <= op.idx;
                  csr_wdata <= op.wdata;
               end
            end else if ((accepted_items > 500 && accepted_items < 800)
                         || $urandom_range(99) >= 25) begin
               void'(pending_ops.pop_front());
               nxt_start = 1;
               req_type <= op.kind;
               req_cell_x <= op.x;
               req_cell_y <= op.y;
               req_cell_value <= op.value;
               req_cell_unknown <= op.unknown;
            end
         end
         if (fill_done && pending_ops.size() == 0 && !nxt_start && !nxt_csr) stim_done = 1;
         start <= nxt_start;
         csr_valid <= nxt_csr;
      end
   end

   // Monitor: every strobed result is matched against the oldest prediction.
   always @(posedge clock) begin
      planner_rsp_t exp_rsp;
      if (!reset && rsp_strobe) begin
         if (awaited_rsps.size() == 0) begin
            $error("unexpected response transaction, status %0d", rsp_status);
            failed = 1;
         end else begin
            exp_rsp = awaited_rsps.pop_front();
            if (rsp_status !== exp_rsp.status) begin
               $error("status expected %0d actual %0d", exp_rsp.status, rsp_status);
               failed = 1;
            end
            if (rsp_path_x !== exp_rsp.px) begin
               $error("path_x expected %0d actual %0d", exp_rsp.px, rsp_path_x);
               failed = 1;
            end
            if (rsp_path_y !== exp_rsp.py) begin
               $error("path_y expected %0d actual %0d", exp_rsp.py, rsp_path_y);
               failed = 1;
            end
            if (rsp_max_cost !== exp_rsp.peak) begin
               $error("max_cost expected %0d actual %0d", exp_rsp.peak, rsp_max_cost);
               failed = 1;
            end
         end
      end
   end

   task automatic add_item(input logic [1:0] kind, input int x = 0, input int y = 0,
                           input int value = 0, input int unknown = 0);
      planner_op_t op;
      op = '{default: 0};
      op.kind = kind;
      op.x = 6'(x);
      op.y = 6'(y);
      op.value = 8'(value);
      op.unknown = 1'(unknown);
      pending_ops = {pending_ops, op};
   endtask

   task automatic add_setup(input int gx, input int gy, input int rx, input int ry,
                            input int fl, input int reach);
      int vals [6];
      planner_op_t op;
      vals = '{gx, gy, rx, ry, fl, reach};
      for (int i = 0; i < 6; i++) begin
         op = '{default: 0};
         op.is_csr = 1;
         op.idx = CSR_IDX_W'(i);
         op.wdata = CSR_DAT_W'(vals[i]);
         pending_ops = {pending_ops, op};
      end
   endtask

   // Random loads stay inside the fenced corner so the ring stays blocked.
   task automatic add_random_load();
      int v;
      v = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(120);
      add_item(REQ_LOAD, $urandom_range(AREA - 1), $urandom_range(AREA - 1), v,
               $urandom_range(15) == 0);
   endtask

   initial begin
      int items, gx, gy, rx, ry, reach, pick;
      // The corner and its ring are written before any plan, and the ring is unknown, so
      // no wavefront ever reads an unwritten cell.
      add_setup(3, 3, 7, 5, 128, 4095);
      for (int y = 0; y <= AREA; y++) begin
         for (int x = 0; x <= AREA; x++) begin
            if (x == AREA || y == AREA)
               add_item(REQ_LOAD, x, y, 255, 1);
            else
               add_item(REQ_LOAD, x, y, $urandom_range(5) == 0 ? 200 : $urandom_range(128),
                        $urandom_range(31) == 0);
         end
      end
      add_item(REQ_STEP);
      add_item(REQ_UNUSED, 5, 5, 0, 0);
      add_item(REQ_LOAD, 6, 4, 128, 0);
      add_item(REQ_LOAD, 5, 4, 129, 0);
      add_item(REQ_PLAN);
      repeat (8) add_item(REQ_STEP);
      add_item(REQ_LOAD, 4, 3, 255, 0);
      add_item(REQ_STEP);
      // Robot on the goal with a zero radius, then an unreachable robot.
      add_setup(AREA - 1, 0, AREA - 1, 0, 255, 0);
      add_item(REQ_LOAD, AREA - 2, 1, 255, 0);
      add_item(REQ_PLAN);
      add_item(REQ_STEP);
      add_setup(0, AREA - 1, 3, AREA - 4, 0, 0);
      add_item(REQ_LOAD, 1, AREA - 2, 0, 0);
      add_item(REQ_PLAN);
      add_item(REQ_STEP);
      items = (AREA + 1) * (AREA + 1) + 21;
      while (items < 1550) begin
         gx = $urandom_range(AREA - 1);
         gy = $urandom_range(AREA - 1);
         rx = gx + $urandom_range(12) - 6;
         ry = gy + $urandom_range(12) - 6;
         rx = rx < 0 ? 0 : (rx > AREA - 1 ? AREA - 1 : rx);
         ry = ry < 0 ? 0 : (ry > AREA - 1 ? AREA - 1 : ry);
         pick = $urandom_range(19);
         reach = pick == 0 ? 4095 : (pick == 1 ? 0 : $urandom_range(40, 160));
         add_setup(gx, gy, rx, ry, $urandom_range(3) == 0 ? $urandom_range(255) : 120, reach);
         repeat (3) begin
            pick = $urandom_range(9);
            if (pick < 6) begin
               add_item(REQ_PLAN);
               items++;
               repeat ($urandom_range(4, 16)) begin
                  add_item(REQ_STEP);
                  items++;
               end
            end
            repeat ($urandom_range(1, 12)) begin
               add_random_load();
               items++;
            end
            if (pick == 9) begin
               add_item(REQ_UNUSED, $urandom_range(63), $urandom_range(63), $urandom_range(255),
                        $urandom_range(1));
               add_item(REQ_STEP);
               items += 2;
            end
         end
      end
      fill_done = 1;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      wait (stim_done);
      while (awaited_rsps.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (!failed) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #200_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
